// ===== src/sconv_pkg.sv =====
// ----------------------------------------------------------------------------
// sconv_pkg
// Shared types and constants of the strided zero-padded convolution block.
// ----------------------------------------------------------------------------
package sconv_pkg;

    localparam int MAX_HEIGHT  = 1024;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 5;
    localparam int DRAIN_CYCLES = 2;

    localparam int ROW_W   = 10;
    localparam int OUTC_W  = 7;
    localparam int COEF_W  = 16;
    localparam int PIX_W   = 8;
    localparam int CIDX_W  = 6;
    localparam int CONV_W  = 32;
    localparam int PROD_W  = 25;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD    = 2'd3;

    localparam logic [7:0]  RST_WIDTH  = 8'd128;
    localparam logic [10:0] RST_HEIGHT = 11'd128;
    localparam logic [3:0]  RST_STRIDE = 4'd4;
    localparam logic [2:0]  RST_PAD    = 3'd2;

    localparam logic ACT_COEF = 1'b0;
    localparam logic ACT_PIX  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_COL,
        ST_MAC,
        ST_DRAIN,
        ST_PUSH,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic pix_load;
        logic coef_load;
        logic row_start;
        logic row_adv;
        logic col_start;
        logic col_adv;
        logic mac_start;
        logic tap_issue;
        logic push;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic row_match;
        logic col_match;
        logic tap_last;
        logic pend_valid;
        logic out_free;
    } status_t;

endpackage

// ===== src/strided_conv2d_zero_pad.sv =====
// ----------------------------------------------------------------------------
// strided_conv2d_zero_pad
// Strided 2D convolution with zero padding over a raster pixel stream.
//
//   channel   dir   fields (lowest bit first)
//   s_        in    tdata: coef_index, coef_value, pixel_value; tuser: action
//   m_        out   tdata: conv_value, out_row, out_col; tlast: last_of_run
//   cfg_      in    cfg_addr selects width, height, stride, pad
//
// A coefficient item is written into the table. A pixel item walks the matching
// output rows and columns and runs a tap loop of KERNEL_SIZE^2 taps per result
// through the single shared multiply-accumulate unit. A new item is accepted only
// when idle, once the last one is finished. Reset clears the positions, the
// walkers and the coefficient valid flags; the line store is not cleared.
// A stalled result holds the output register; the block stalls when a finished
// result or the end of an item finds the held result and the output register full.
// ----------------------------------------------------------------------------
module strided_conv2d_zero_pad #(
    parameter int KERNEL_SIZE = 8,
    parameter int MAX_WIDTH   = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [10:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // coef_index, coef_value, pixel_value
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // conv_value, out_row, out_col
    output logic        m_tlast
);

    sconv_pkg::cmd_t    cmd;
    sconv_pkg::status_t st;

    sconv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    sconv_dp #(
        .KERNEL_SIZE (KERNEL_SIZE),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== src/sconv_ctrl.sv =====
// ----------------------------------------------------------------------------
// sconv_ctrl
// Sequencer: walks matching output rows and columns, runs the tap loop.
// ----------------------------------------------------------------------------
module sconv_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tuser,
    output logic               s_tready,
    input  sconv_pkg::status_t st,
    output sconv_pkg::cmd_t    cmd
);

    sconv_pkg::state_t state_reg, state_next;
    logic [sconv_pkg::CNT_W-1:0] count_reg, count_next;
    logic [1:0] drain_reg, drain_next;
    logic row_seen_reg, row_seen_next;
    logic emit_reg, emit_next;
    logic cap_ok;

    assign cap_ok   = count_reg < sconv_pkg::CNT_W'(sconv_pkg::MAX_RESULTS);
    assign s_tready = (state_reg == sconv_pkg::ST_IDLE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sconv_pkg::ST_IDLE: begin
                if (s_tvalid && s_tuser == sconv_pkg::ACT_PIX) state_next = sconv_pkg::ST_ROW;
            end
            sconv_pkg::ST_ROW: begin
                if (st.row_match || !row_seen_reg) state_next = sconv_pkg::ST_COL;
                else state_next = sconv_pkg::ST_FIN;
            end
            sconv_pkg::ST_COL: begin
                if (st.col_match) begin
                    if (emit_reg && cap_ok) state_next = sconv_pkg::ST_MAC;
                end else begin
                    state_next = sconv_pkg::ST_ROW;
                end
            end
            sconv_pkg::ST_MAC: begin
                if (st.tap_last) state_next = sconv_pkg::ST_DRAIN;
            end
            sconv_pkg::ST_DRAIN: begin
                if (drain_reg == 2'(sconv_pkg::DRAIN_CYCLES - 1)) state_next = sconv_pkg::ST_PUSH;
            end
            sconv_pkg::ST_PUSH: begin
                if (!st.pend_valid || st.out_free) state_next = sconv_pkg::ST_COL;
            end
            sconv_pkg::ST_FIN: begin
                if (!st.pend_valid || st.out_free) state_next = sconv_pkg::ST_IDLE;
            end
            default: state_next = sconv_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            sconv_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == sconv_pkg::ACT_PIX) begin
                        cmd.pix_load  = 1'b1;
                        cmd.row_start = 1'b1;
                    end else begin
                        cmd.coef_load = 1'b1;
                    end
                end
            end
            sconv_pkg::ST_ROW: begin
                if (st.row_match || !row_seen_reg) cmd.col_start = 1'b1;
            end
            sconv_pkg::ST_COL: begin
                if (st.col_match) begin
                    if (emit_reg && cap_ok) cmd.mac_start = 1'b1;
                    else cmd.col_adv = 1'b1;
                end else if (emit_reg) begin
                    cmd.row_adv = 1'b1;
                end
            end
            sconv_pkg::ST_MAC: cmd.tap_issue = 1'b1;
            sconv_pkg::ST_PUSH: begin
                if (!st.pend_valid || st.out_free) begin
                    cmd.push    = 1'b1;
                    cmd.col_adv = 1'b1;
                end
            end
            sconv_pkg::ST_FIN: begin
                if (!st.pend_valid || st.out_free) cmd.fin = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

    always_comb begin
        count_next    = count_reg;
        drain_next    = drain_reg;
        row_seen_next = row_seen_reg;
        emit_next     = emit_reg;
        if (cmd.pix_load) begin
            count_next    = '0;
            row_seen_next = 1'b0;
        end
        if (cmd.col_start) begin
            row_seen_next = 1'b1;
            emit_next     = st.row_match;
        end
        if (state_reg == sconv_pkg::ST_MAC) drain_next = '0;
        if (state_reg == sconv_pkg::ST_DRAIN) drain_next = drain_reg + 2'd1;
        if (cmd.push) count_next = count_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sconv_pkg::ST_IDLE;
            count_reg    <= '0;
            drain_reg    <= '0;
            row_seen_reg <= 1'b0;
            emit_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            drain_reg    <= drain_next;
            row_seen_reg <= row_seen_next;
            emit_reg     <= emit_next;
        end
    end

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push || cmd.fin) && st.pend_valid |-> st.out_free)
        else $error("result moved into a busy output register");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= sconv_pkg::CNT_W'(sconv_pkg::MAX_RESULTS))
        else $error("result count beyond limit");

    a_mac_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mac_start |-> emit_reg && cap_ok)
        else $error("tap loop started without room for a result");

    a_fin_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin |=> state_reg == sconv_pkg::ST_IDLE)
        else $error("finish did not return to idle");

endmodule

// ===== src/sconv_dp.sv =====
// ----------------------------------------------------------------------------
// sconv_dp
// Datapath: config, positions, window walkers, line store, taps, MAC, output.
// ----------------------------------------------------------------------------
module sconv_dp #(
    parameter int KERNEL_SIZE = 8,
    parameter int MAX_WIDTH   = 128
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sconv_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [sconv_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [31:0]                         s_tdata,
    input  sconv_pkg::cmd_t                     cmd,
    output sconv_pkg::status_t                  st,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [55:0]                         m_tdata,
    output logic                                m_tlast
);

    localparam int K     = KERNEL_SIZE;
    localparam int TAPS  = K * K;
    localparam int KW    = $clog2(K);
    localparam int TW    = $clog2(TAPS);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int XS    = CW + 3;
    localparam int YS    = 13;
    localparam int OYW   = 11;
    localparam int ACC_W = sconv_pkg::PROD_W + TW;

    logic [7:0]  width_reg;
    logic [10:0] height_reg;
    logic [3:0]  stride_reg;
    logic [2:0]  pad_reg;

    logic [sconv_pkg::ROW_W-1:0] row_pos_reg;
    logic [XW-1:0]               col_pos_reg;
    logic [KW-1:0]               rslot_reg;

    logic [OYW-1:0]       row_ptr_oy_reg, row_w_oy_reg;
    logic signed [YS-1:0] row_ptr_b_reg, row_w_b_reg;
    logic [CW-1:0]        col_ptr_ox_reg, col_w_ox_reg;
    logic signed [XS-1:0] col_ptr_b_reg, col_w_b_reg;

    logic [KW-1:0] k_reg, m_reg;
    logic [TW-1:0] tap_reg;

    logic [7:0]  line_mem [K][MAX_WIDTH];
    logic signed [sconv_pkg::COEF_W-1:0] coef_mem [TAPS];
    logic [TAPS-1:0] coef_vld_reg;

    logic        s1_v_reg, s1_in_reg, s2_v_reg;
    logic [7:0]  px_rd_reg;
    logic signed [sconv_pkg::COEF_W-1:0] coef_rd_reg;
    logic        coef_rd_v_reg;
    logic signed [sconv_pkg::PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic [31:0] pend_val_reg;
    logic [sconv_pkg::ROW_W-1:0]  pend_row_reg;
    logic [sconv_pkg::OUTC_W-1:0] pend_col_reg;
    logic        pend_v_reg;
    logic [31:0] out_val_reg;
    logic [sconv_pkg::ROW_W-1:0]  out_row_reg;
    logic [sconv_pkg::OUTC_W-1:0] out_col_reg;
    logic        out_last_reg, out_v_reg;

    logic [CW-1:0] w_eff;
    logic [10:0]   h_eff;
    logic [3:0]    s_eff;
    logic [11:0]   w_wide;

    logic signed [YS-1:0] kp_y, h_s, r_s, row_t, y, d_full;
    logic signed [XS-1:0] kp_x, w_s, c_s, col_t, x;
    logic                 row_hit, col_hit, y_in, x_in;
    logic [KW-1:0]        d, slot;

    logic [sconv_pkg::CIDX_W-1:0] cidx_in;
    logic signed [sconv_pkg::COEF_W-1:0] cval_in;
    logic [sconv_pkg::PIX_W-1:0] pix_in;
    logic        cidx_ok;
    logic signed [63:0] acc_ext;
    logic [31:0] sat_val;
    logic        row_last, col_last;

    assign cidx_in = s_tdata[5:0];
    assign cval_in = s_tdata[21:6];
    assign pix_in  = s_tdata[29:22];
    assign cidx_ok = 32'(cidx_in) < TAPS;

    always_comb begin
        w_wide = {4'd0, width_reg};
        if (width_reg == 8'd0) w_eff = CW'(1);
        else if (w_wide > 12'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
        else w_eff = CW'(w_wide);
        if (height_reg == 11'd0) h_eff = 11'd1;
        else if (height_reg > 11'(sconv_pkg::MAX_HEIGHT)) h_eff = 11'(sconv_pkg::MAX_HEIGHT);
        else h_eff = height_reg;
        s_eff = (stride_reg == 4'd0) ? 4'd1 : stride_reg;
    end

    always_comb begin
        kp_y  = $signed(YS'(K - 1)) - $signed(YS'(pad_reg));
        kp_x  = $signed(XS'(K - 1)) - $signed(XS'(pad_reg));
        h_s   = $signed(YS'(h_eff));
        w_s   = $signed(XS'(w_eff));
        r_s   = $signed(YS'(row_pos_reg));
        c_s   = $signed(XS'(col_pos_reg));
        row_t = row_w_b_reg + kp_y;
        col_t = col_w_b_reg + kp_x;
        row_hit = (row_w_b_reg + $signed(YS'(s_eff)) <= h_s) &&
                  ((row_t == r_s) || (row_t < 0 && r_s == 0) ||
                   (row_t > h_s - 1 && r_s == h_s - 1));
        col_hit = (col_w_b_reg + $signed(XS'(s_eff)) <= w_s) &&
                  ((col_t == c_s) || (col_t < 0 && c_s == 0) ||
                   (col_t > w_s - 1 && c_s == w_s - 1));
        y      = row_w_b_reg - $signed(YS'(pad_reg)) + $signed(YS'(k_reg));
        x      = col_w_b_reg - $signed(XS'(pad_reg)) + $signed(XS'(m_reg));
        y_in   = (y >= 0) && (y < h_s);
        x_in   = (x >= 0) && (x < w_s);
        d_full = r_s - y;
        d      = d_full[KW-1:0];
        if (rslot_reg >= d) slot = rslot_reg - d;
        else slot = KW'({1'b0, rslot_reg} + (KW+1)'(K) - {1'b0, d});
        row_last = (32'(row_pos_reg) == 32'(h_eff) - 1);
        col_last = (32'(col_pos_reg) == 32'(w_eff) - 1);
    end

    always_comb begin
        acc_ext = {{(64-ACC_W){acc_reg[ACC_W-1]}}, acc_reg};
        if (acc_ext > 64'sh7FFF_FFFF) sat_val = 32'h7FFF_FFFF;
        else if (acc_ext < -64'sh8000_0000) sat_val = 32'h8000_0000;
        else sat_val = acc_ext[31:0];
    end

    assign st.row_match  = row_hit;
    assign st.col_match  = col_hit;
    assign st.tap_last   = (tap_reg == TW'(TAPS - 1));
    assign st.pend_valid = pend_v_reg;
    assign st.out_free   = !out_v_reg || m_tready;

    // configuration, positions and walkers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= sconv_pkg::RST_WIDTH;
            height_reg     <= sconv_pkg::RST_HEIGHT;
            stride_reg     <= sconv_pkg::RST_STRIDE;
            pad_reg        <= sconv_pkg::RST_PAD;
            row_pos_reg    <= '0;
            col_pos_reg    <= '0;
            rslot_reg      <= '0;
            row_ptr_oy_reg <= '0;
            row_ptr_b_reg  <= '0;
            col_ptr_ox_reg <= '0;
            col_ptr_b_reg  <= '0;
            row_w_oy_reg   <= '0;
            row_w_b_reg    <= '0;
            col_w_ox_reg   <= '0;
            col_w_b_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                sconv_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata[7:0];
                sconv_pkg::CFG_HEIGHT: height_reg <= cfg_wdata;
                sconv_pkg::CFG_STRIDE: stride_reg <= cfg_wdata[3:0];
                sconv_pkg::CFG_PAD:    pad_reg    <= cfg_wdata[2:0];
                default: width_reg <= width_reg;
            endcase
            row_pos_reg    <= '0;
            col_pos_reg    <= '0;
            rslot_reg      <= '0;
            row_ptr_oy_reg <= '0;
            row_ptr_b_reg  <= '0;
            col_ptr_ox_reg <= '0;
            col_ptr_b_reg  <= '0;
        end else begin
            if (cmd.row_start) begin
                row_w_oy_reg <= row_ptr_oy_reg;
                row_w_b_reg  <= row_ptr_b_reg;
            end
            if (cmd.row_adv) begin
                row_w_oy_reg <= row_w_oy_reg + 1'b1;
                row_w_b_reg  <= row_w_b_reg + $signed(YS'(s_eff));
            end
            if (cmd.col_start) begin
                col_w_ox_reg <= col_ptr_ox_reg;
                col_w_b_reg  <= col_ptr_b_reg;
            end
            if (cmd.col_adv) begin
                col_w_ox_reg <= col_w_ox_reg + 1'b1;
                col_w_b_reg  <= col_w_b_reg + $signed(XS'(s_eff));
            end
            if (cmd.fin) begin
                if (col_last) begin
                    col_pos_reg    <= '0;
                    col_ptr_ox_reg <= '0;
                    col_ptr_b_reg  <= '0;
                    if (row_last) begin
                        row_pos_reg    <= '0;
                        rslot_reg      <= '0;
                        row_ptr_oy_reg <= '0;
                        row_ptr_b_reg  <= '0;
                    end else begin
                        row_pos_reg    <= row_pos_reg + 1'b1;
                        rslot_reg      <= (rslot_reg == KW'(K - 1)) ? '0 : rslot_reg + 1'b1;
                        row_ptr_oy_reg <= row_w_oy_reg;
                        row_ptr_b_reg  <= row_w_b_reg;
                    end
                end else begin
                    col_pos_reg    <= col_pos_reg + 1'b1;
                    col_ptr_ox_reg <= col_w_ox_reg;
                    col_ptr_b_reg  <= col_w_b_reg;
                end
            end
        end
    end

    // tap counters and pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg    <= '0;
            m_reg    <= '0;
            tap_reg  <= '0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            coef_vld_reg <= '0;
        end else begin
            if (cmd.mac_start) begin
                k_reg   <= '0;
                m_reg   <= '0;
                tap_reg <= '0;
            end else if (cmd.tap_issue) begin
                tap_reg <= tap_reg + 1'b1;
                if (m_reg == KW'(K - 1)) begin
                    m_reg <= '0;
                    k_reg <= k_reg + 1'b1;
                end else begin
                    m_reg <= m_reg + 1'b1;
                end
            end
            s1_v_reg <= cmd.tap_issue;
            s2_v_reg <= s1_v_reg;
            if (cmd.coef_load && cidx_ok) coef_vld_reg[TW'(cidx_in)] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pix_load) line_mem[rslot_reg][col_pos_reg] <= pix_in;
        px_rd_reg <= line_mem[slot][x[XW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.coef_load && cidx_ok) coef_mem[TW'(cidx_in)] <= cval_in;
        coef_rd_reg <= coef_mem[tap_reg];
    end

    always_ff @(posedge aclk) begin
        coef_rd_v_reg <= coef_vld_reg[tap_reg];
        s1_in_reg     <= y_in && x_in;
        if (s1_in_reg && coef_rd_v_reg)
            prod_reg <= coef_rd_reg * $signed({1'b0, px_rd_reg});
        else
            prod_reg <= '0;
        if (cmd.mac_start)
            acc_reg <= '0;
        else if (s2_v_reg)
            acc_reg <= acc_reg + {{(ACC_W-sconv_pkg::PROD_W){prod_reg[sconv_pkg::PROD_W-1]}},
                                  prod_reg};
    end

    // hold one finished result back to mark the final one of an item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            if ((cmd.push || cmd.fin) && pend_v_reg) out_v_reg <= 1'b1;
            else if (m_tready) out_v_reg <= 1'b0;
            if (cmd.push) pend_v_reg <= 1'b1;
            else if (cmd.fin) pend_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((cmd.push || cmd.fin) && pend_v_reg) begin
            out_val_reg  <= pend_val_reg;
            out_row_reg  <= pend_row_reg;
            out_col_reg  <= pend_col_reg;
            out_last_reg <= cmd.fin;
        end
        if (cmd.push) begin
            pend_val_reg <= sat_val;
            pend_row_reg <= row_w_oy_reg[sconv_pkg::ROW_W-1:0];
            pend_col_reg <= sconv_pkg::OUTC_W'(col_w_ox_reg);
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_col_reg, out_row_reg, out_val_reg};

endmodule
